@@ rtl/core/lcmsg_pkg.sv @@
// shared constants and controller/datapath interface types for the lcm core
package lcmsg_pkg;

	// operand width used by the gcd, divide and multiply datapath
	localparam int WIDTH = 16;

	// fixed field widths of the request and result ports
	localparam int IN_W  = 16;
	localparam int LCM_W = 32;
	localparam int GCD_W = 16;

	// divide step counter
	localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WIDTH - 1);

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture operands of a new request
		logic step_gcd;   // one subtraction of the smaller from the larger
		logic div_init;   // clear remainder, load dividend
		logic div_step;   // one restoring division bit
		logic mul;        // quotient times second operand
		logic write_out;  // load the result register
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic in_zero;    // an operand on the request ports is zero
		logic eq;         // both gcd registers hold the same value
		logic div_last;   // final division bit in progress
	} sts_t;

endpackage

@@ rtl/core/lcmsg_ctrl.sv @@
// controller state machine sequencing gcd, divide, multiply and result hand-off
module lcmsg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  lcmsg_pkg::sts_t     sts,
	output lcmsg_pkg::cmd_t     cmd
);
	import lcmsg_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GCD  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	// result register can take a new value when empty or being drained
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = sts.in_zero ? ST_WR : ST_GCD;
				end
			end
			ST_GCD: begin
				if (sts.eq) begin
					cmd.div_init = 1'b1;
					state_nxt    = ST_DIV;
				end else begin
					cmd.step_gcd = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_WR;
			end
			ST_WR: begin
				if (out_free) begin
					cmd.write_out = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.write_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/lcmsg_dpath.sv @@
// datapath: subtractive gcd, restoring divider, multiplier and result register
module lcmsg_dpath (
	input  logic                          clk,
	input  logic [lcmsg_pkg::IN_W-1:0]    a,
	input  logic [lcmsg_pkg::IN_W-1:0]    b,
	input  lcmsg_pkg::cmd_t               cmd,
	output lcmsg_pkg::sts_t               sts,
	output logic [lcmsg_pkg::LCM_W-1:0]   lcm,
	output logic [lcmsg_pkg::GCD_W-1:0]   gcd,
	output logic                          valid_res
);
	import lcmsg_pkg::*;

	logic [WIDTH-1:0]   a_op;
	logic [WIDTH-1:0]   b_op;
	logic [WIDTH-1:0]   x_q;
	logic [WIDTH-1:0]   y_q;
	logic [WIDTH-1:0]   a_q;
	logic [WIDTH-1:0]   b_q;
	logic               zero_q;
	logic [WIDTH-1:0]   rem_q;
	logic [WIDTH-1:0]   quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [2*WIDTH-1:0] prod_q;
	logic [WIDTH:0]     trial;
	logic               trial_ge;
	logic [WIDTH:0]     trial_sub;
	logic [LCM_W-1:0]   lcm_q;
	logic [GCD_W-1:0]   gcd_q;
	logic               valid_res_q;

	// operands are resized to the datapath width; with WIDTH equal to IN_W all bits take part
	assign a_op = WIDTH'(a);
	assign b_op = WIDTH'(b);

	assign sts.in_zero  = (a_op == '0) || (b_op == '0);
	assign sts.eq       = (x_q == y_q);
	assign sts.div_last = (cnt_q == DIV_LAST);

	// one restoring division bit: shift in next dividend bit, try subtracting gcd
	assign trial     = {rem_q, quo_q[WIDTH-1]};
	assign trial_ge  = (trial >= {1'b0, x_q});
	assign trial_sub = trial - {1'b0, x_q};

	// operand capture and gcd subtraction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= a_op;
			y_q    <= b_op;
			a_q    <= a_op;
			b_q    <= b_op;
			zero_q <= (a_op == '0) || (b_op == '0);
		end else if (cmd.step_gcd) begin
			if (x_q > y_q) begin
				x_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
	end

	// divider: first operand over gcd, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= a_q;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], trial_ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// multiply quotient by second operand
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= quo_q * b_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.write_out) begin
			if (zero_q) begin
				lcm_q       <= '0;
				gcd_q       <= '0;
				valid_res_q <= 1'b0;
			end else begin
				lcm_q       <= LCM_W'(prod_q);
				gcd_q       <= GCD_W'(x_q);
				valid_res_q <= 1'b1;
			end
		end
	end

	assign lcm       = lcm_q;
	assign gcd       = gcd_q;
	assign valid_res = valid_res_q;

endmodule

@@ rtl/core/lcm_by_subtractive_gcd_core.sv @@
// top level of the lcm core: controller plus datapath
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------
//  request  | in_valid / in_ready  | a, b
//  result   | out_valid / out_ready| lcm, gcd, valid_res
//
// a request takes a load, the gcd subtractions (up to 2^WIDTH-2 of them), an
// equality check, WIDTH divide steps, a multiply and a write; a zero operand goes
// from the load straight to the write.
// the subtraction loop of the gcd registers sets how long a request takes.
// in_ready is high only while idle; a finished result waits in the result
// register, and a new request is accepted while it waits there.
// arst_n clears the controller and the result valid flag.
module lcm_by_subtractive_gcd_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lcmsg_pkg::IN_W-1:0]    a,
	input  logic [lcmsg_pkg::IN_W-1:0]    b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lcmsg_pkg::LCM_W-1:0]   lcm,
	output logic [lcmsg_pkg::GCD_W-1:0]   gcd,
	output logic                          valid_res
);
	import lcmsg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	lcmsg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic and result register
	lcmsg_dpath u_dpath (
		.clk       (clk),
		.a         (a),
		.b         (b),
		.cmd       (cmd),
		.sts       (sts),
		.lcm       (lcm),
		.gcd       (gcd),
		.valid_res (valid_res)
	);

endmodule

@@ rtl/core/lcmsg_checker.sv @@
// port-level checker for the lcm core and its bind
module lcmsg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [lcmsg_pkg::LCM_W-1:0]   lcm,
	input logic [lcmsg_pkg::GCD_W-1:0]   gcd,
	input logic                          valid_res
);
	import lcmsg_pkg::*;

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(lcm) && $stable(gcd) && $stable(valid_res))
		else $error("result payload changed while stalled");

	// an invalid result carries zero lcm and gcd
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> lcm == '0 && gcd == '0)
		else $error("invalid result with nonzero fields");

	// the core is busy in the cycle after a request is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

endmodule

bind lcm_by_subtractive_gcd_core lcmsg_checker u_lcmsg_checker (.*);
